[design/lfps_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants, decode table and microprogram for the line follower steering block
package lfps_pkg;

    localparam int SENSOR_W = 6;
    localparam int ERR_W    = 5;
    localparam int SPEED_W  = 7;
    localparam int GAIN_W   = 16;
    localparam int BASE_W   = 7;
    localparam int BIAS_W   = 6;
    localparam int DIFF_W   = 7;
    localparam int INTEG_W  = 16;
    localparam int CORR_W   = 16;
    localparam int DRIVE_W  = 8;
    localparam int MUL_W    = 17;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = 36;
    localparam int SIDE_W   = 18;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int OUT_LIMIT   = 25600;
    localparam int DRIVE_LIMIT = 100;
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd5120;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd14080;
    localparam logic [BASE_W-1:0] BASE_L_RST = 7'd70;
    localparam logic [BASE_W-1:0] BASE_R_RST = 7'd76;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_L = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_R = 3'd5;

    localparam logic [STEP_W-1:0] ST_FETCH = 4'd0;
    localparam logic [STEP_W-1:0] ST_SIDE  = 4'd8;
    localparam logic [STEP_W-1:0] ST_WAIT  = 4'd12;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_DECODE,
        OP_BIAS,
        OP_INTEG,
        OP_MUL_LOAD,
        OP_MUL_ADD,
        OP_CLAMP,
        OP_SIDE,
        OP_STORE,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        A_GAIN_P,
        A_GAIN_I,
        A_GAIN_D,
        A_MAG,
        A_ACC
    } t_asel;

    typedef enum logic [2:0] {
        B_BIAS,
        B_INTEG,
        B_DIFF,
        B_SPEED,
        B_RECIP
    } t_bsel;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_LEFT,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_asel             asel;
        t_bsel             bsel;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic                     hit;
        logic                     brake;
        logic signed [ERR_W-1:0]  err;
        logic [SPEED_W-1:0]       speed;
    } t_dec;

    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword uw;
        uw = '{op: OP_NOP, asel: A_GAIN_P, bsel: B_BIAS, cond: C_NONE, target: ST_FETCH};
        case (step)
            4'd0: begin
                uw.op = OP_FETCH;
                uw.cond = C_NO_IN;
                uw.target = ST_FETCH;
            end
            4'd1: uw.op = OP_DECODE;
            4'd2: uw.op = OP_BIAS;
            4'd3: uw.op = OP_INTEG;
            4'd4: begin
                uw.op = OP_MUL_LOAD;
                uw.asel = A_GAIN_P;
                uw.bsel = B_BIAS;
            end
            4'd5: begin
                uw.op = OP_MUL_ADD;
                uw.asel = A_GAIN_I;
                uw.bsel = B_INTEG;
            end
            4'd6: begin
                uw.op = OP_MUL_ADD;
                uw.asel = A_GAIN_D;
                uw.bsel = B_DIFF;
            end
            4'd7: uw.op = OP_CLAMP;
            4'd8: uw.op = OP_SIDE;
            4'd9: begin
                uw.op = OP_MUL_LOAD;
                uw.asel = A_MAG;
                uw.bsel = B_SPEED;
            end
            4'd10: begin
                uw.op = OP_MUL_LOAD;
                uw.asel = A_ACC;
                uw.bsel = B_RECIP;
            end
            4'd11: begin
                uw.op = OP_STORE;
                uw.cond = C_LEFT;
                uw.target = ST_SIDE;
            end
            4'd12: begin
                uw.op = OP_NOP;
                uw.cond = C_OUT_FULL;
                uw.target = ST_WAIT;
            end
            4'd13: begin
                uw.op = OP_EMIT;
                uw.cond = C_ALWAYS;
                uw.target = ST_FETCH;
            end
            default: begin
                uw.op = OP_NOP;
                uw.cond = C_ALWAYS;
                uw.target = ST_FETCH;
            end
        endcase
        return uw;
    endfunction

    function automatic t_dec decode(input logic [SENSOR_W-1:0] pat);
        t_dec d;
        d = '{hit: 1'b1, brake: 1'b0, err: 5'sd0, speed: 7'd0};
        case (pat)
            6'b111000: begin d.err = -5'sd11; d.speed = 7'd100; end
            6'b100000: begin d.err = -5'sd9;  d.speed = 7'd80;  end
            6'b110000: begin d.err = -5'sd7;  d.speed = 7'd85;  end
            6'b010000: begin d.err = -5'sd5;  d.speed = 7'd90;  end
            6'b011000: begin d.err = -5'sd3;  d.speed = 7'd95;  end
            6'b001000: begin d.err = -5'sd1;  d.speed = 7'd95;  end
            6'b000000: begin d.err = 5'sd0;   d.speed = 7'd100; end
            6'b000100: begin d.err = 5'sd1;   d.speed = 7'd95;  end
            6'b000110: begin d.err = 5'sd3;   d.speed = 7'd80;  end
            6'b000010: begin d.err = 5'sd5;   d.speed = 7'd85;  end
            6'b000011: begin d.err = 5'sd7;   d.speed = 7'd90;  end
            6'b000001: begin d.err = 5'sd9;   d.speed = 7'd95;  end
            6'b000111: begin d.err = 5'sd11;  d.speed = 7'd100; end
            6'b111111: begin d.brake = 1'b1;  d.speed = 7'd0;   end
            default:   d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[design/line_follow_pid_steering_top.sv]
`timescale 1ns / 1ps
// line follower steering controller: sensor decode, pid step and drive scaling
// One sensor transaction in gives one drive transaction out. A 14-entry microprogram
// steps a small datapath built around one shared 17x17 multiplier. The multiplier is used
// seven times per item: three times for the pid terms, then twice for each side, once for
// speed scaling and once for divide-by-100. The side steps run twice, left side first, and
// the result is emitted once both sides are stored. A new item is taken only once the
// program is back at its fetch step. The finished result sits in an output register;
// the next sensor transaction is accepted while it waits, and the program holds before its
// final step only while that register is still full.
// Configuration writes are always ready and should be issued only while the block is idle.
module line_follow_pid_steering_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lfps_pkg::SENSOR_W-1:0]      i_sensor_bits,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [lfps_pkg::DRIVE_W-1:0] o_left_drive,
    output logic signed [lfps_pkg::DRIVE_W-1:0] o_right_drive,
    output logic signed [lfps_pkg::ERR_W-1:0]  o_track_error,
    output logic [lfps_pkg::SPEED_W-1:0]       o_speed_percent,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ACC_W  = lfps_pkg::ACC_W;
    localparam int SIDE_W = lfps_pkg::SIDE_W;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(lfps_pkg::OUT_LIMIT);
    localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(lfps_pkg::OUT_LIMIT);
    localparam logic signed [lfps_pkg::CORR_W-1:0] CORR_HI =
        lfps_pkg::CORR_W'(lfps_pkg::OUT_LIMIT);
    localparam logic signed [lfps_pkg::CORR_W-1:0] CORR_LO =
        -lfps_pkg::CORR_W'(lfps_pkg::OUT_LIMIT);
    localparam logic [9:0] DRV_LIM = 10'(lfps_pkg::DRIVE_LIMIT);

    // configuration
    logic [lfps_pkg::GAIN_W-1:0]        r_gain_p, r_gain_i, r_gain_d;
    logic signed [lfps_pkg::ERR_W-1:0]  r_target;
    logic [lfps_pkg::BASE_W-1:0]        r_base_l, r_base_r;

    // sequencer and datapath
    logic [lfps_pkg::STEP_W-1:0]        r_step, n_step;
    logic [lfps_pkg::SENSOR_W-1:0]      r_sensor, n_sensor;
    logic signed [lfps_pkg::ERR_W-1:0]  r_held_err, n_held_err;
    logic [lfps_pkg::SPEED_W-1:0]       r_held_spd, n_held_spd;
    logic signed [lfps_pkg::BIAS_W-1:0] r_bias, n_bias, r_prev, n_prev;
    logic signed [lfps_pkg::INTEG_W-1:0] r_integ, n_integ;
    logic signed [ACC_W-1:0]            r_acc, n_acc;
    logic signed [lfps_pkg::CORR_W-1:0] r_corr, n_corr;
    logic                               r_right_sel, n_right_sel;
    logic                               r_neg, n_neg;
    logic [lfps_pkg::SPEED_W-1:0]       r_mag, n_mag;
    logic [lfps_pkg::DRIVE_W-1:0]       r_left, n_left, r_right, n_right;

    // output register
    logic                               r_out_valid, n_out_valid;
    logic [lfps_pkg::DRIVE_W-1:0]       r_out_left, n_out_left, r_out_right, n_out_right;
    logic [lfps_pkg::ERR_W-1:0]         r_out_err, n_out_err;
    logic [lfps_pkg::SPEED_W-1:0]       r_out_spd, n_out_spd;

    lfps_pkg::t_uword uw;
    lfps_pkg::t_dec   dec;
    logic             in_accept, out_accept, cond_true;

    logic signed [lfps_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [lfps_pkg::PROD_W-1:0] prod;
    logic signed [lfps_pkg::DIFF_W-1:0] diff;
    logic signed [lfps_pkg::INTEG_W:0]  integ_sum;
    logic signed [SIDE_W-1:0]           side_base, side_corr, side_sum, side_adj;
    logic signed [9:0]                  side_q;
    logic [9:0]                         side_abs;
    logic [lfps_pkg::DRIVE_W-1:0]       st_q, st_val;

    assign uw          = lfps_pkg::ucode(r_step);
    assign dec         = lfps_pkg::decode(r_sensor);
    assign o_in_stall  = (r_step != lfps_pkg::ST_FETCH);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = r_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_left_drive    = r_out_left;
    assign o_right_drive   = r_out_right;
    assign o_track_error   = r_out_err;
    assign o_speed_percent = r_out_spd;

    // shared multiplier operands
    always_comb begin
        case (uw.asel)
            lfps_pkg::A_GAIN_P: mul_a = {1'b0, r_gain_p};
            lfps_pkg::A_GAIN_I: mul_a = {1'b0, r_gain_i};
            lfps_pkg::A_GAIN_D: mul_a = {1'b0, r_gain_d};
            lfps_pkg::A_MAG:    mul_a = {10'd0, r_mag};
            lfps_pkg::A_ACC:    mul_a = {3'd0, r_acc[13:0]};
            default:            mul_a = '0;
        endcase
        case (uw.bsel)
            lfps_pkg::B_BIAS:  mul_b = {{11{r_bias[5]}}, r_bias};
            lfps_pkg::B_INTEG: mul_b = {r_integ[15], r_integ};
            lfps_pkg::B_DIFF:  mul_b = {{10{diff[6]}}, diff};
            lfps_pkg::B_SPEED: mul_b = {10'd0, r_held_spd};
            lfps_pkg::B_RECIP: mul_b = lfps_pkg::MUL_W'(lfps_pkg::RECIP_100);
            default:           mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;
    assign diff = {r_bias[5], r_bias} - {r_prev[5], r_prev};
    assign integ_sum = {r_integ[15], r_integ} + {{11{r_bias[5]}}, r_bias};

    // one side of the drive: base +/- correction, divide by 256 toward zero, clamp
    always_comb begin
        side_base = {3'd0, (r_right_sel ? r_base_r : r_base_l), 8'd0};
        side_corr = {{2{r_corr[15]}}, r_corr};
        side_sum  = r_right_sel ? (side_base - side_corr) : (side_base + side_corr);
        side_adj  = side_sum[SIDE_W-1] ? (side_sum + 18'sd255) : side_sum;
        side_q    = side_adj[SIDE_W-1:8];
        side_abs  = side_q[9] ? (10'd0 - side_q) : side_q;
    end

    assign st_q   = {1'b0, r_acc[lfps_pkg::RECIP_SHIFT +: lfps_pkg::SPEED_W]};
    assign st_val = r_neg ? (8'd0 - st_q) : st_q;

    // step sequencing
    always_comb begin
        case (uw.cond)
            lfps_pkg::C_NONE:     cond_true = 1'b0;
            lfps_pkg::C_ALWAYS:   cond_true = 1'b1;
            lfps_pkg::C_NO_IN:    cond_true = !i_in_valid;
            lfps_pkg::C_LEFT:     cond_true = !r_right_sel;
            lfps_pkg::C_OUT_FULL: cond_true = r_out_valid && i_out_stall;
            default:              cond_true = 1'b0;
        endcase
        n_step = cond_true ? uw.target : r_step + 4'd1;
    end

    // datapath actions
    always_comb begin
        n_sensor    = r_sensor;
        n_held_err  = r_held_err;
        n_held_spd  = r_held_spd;
        n_bias      = r_bias;
        n_prev      = r_prev;
        n_integ     = r_integ;
        n_acc       = r_acc;
        n_corr      = r_corr;
        n_right_sel = r_right_sel;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_left      = r_left;
        n_right     = r_right;
        n_out_valid = out_accept ? 1'b0 : r_out_valid;
        n_out_left  = r_out_left;
        n_out_right = r_out_right;
        n_out_err   = r_out_err;
        n_out_spd   = r_out_spd;
        case (uw.op)
            lfps_pkg::OP_FETCH: begin
                if (in_accept) begin
                    n_sensor = i_sensor_bits;
                end
                n_right_sel = 1'b0;
            end
            lfps_pkg::OP_DECODE: begin
                if (dec.hit) begin
                    if (!dec.brake) begin
                        n_held_err = dec.err;
                    end
                    n_held_spd = dec.speed;
                end
            end
            lfps_pkg::OP_BIAS: begin
                n_prev = r_bias;
                n_bias = {r_held_err[4], r_held_err} - {r_target[4], r_target};
            end
            lfps_pkg::OP_INTEG: begin
                if (r_gain_i == '0) begin
                    n_integ = '0;
                end else if (integ_sum[16] != integ_sum[15]) begin
                    n_integ = integ_sum[16] ? 16'sh8000 : 16'sh7FFF;
                end else begin
                    n_integ = integ_sum[15:0];
                end
            end
            lfps_pkg::OP_MUL_LOAD: n_acc = {{2{prod[33]}}, prod};
            lfps_pkg::OP_MUL_ADD:  n_acc = r_acc + {{2{prod[33]}}, prod};
            lfps_pkg::OP_CLAMP: begin
                if (r_acc > ACC_HI) begin
                    n_corr = CORR_HI;
                end else if (r_acc < ACC_LO) begin
                    n_corr = CORR_LO;
                end else begin
                    n_corr = r_acc[15:0];
                end
            end
            lfps_pkg::OP_SIDE: begin
                n_neg = side_q[9];
                n_mag = (side_abs > DRV_LIM) ? lfps_pkg::SPEED_W'(lfps_pkg::DRIVE_LIMIT)
                                             : side_abs[6:0];
            end
            lfps_pkg::OP_STORE: begin
                if (r_right_sel) begin
                    n_right = st_val;
                end else begin
                    n_left = st_val;
                end
                n_right_sel = 1'b1;
            end
            lfps_pkg::OP_EMIT: begin
                n_out_valid = 1'b1;
                n_out_left  = r_left;
                n_out_right = r_right;
                n_out_err   = r_held_err;
                n_out_spd   = r_held_spd;
            end
            default: begin
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= lfps_pkg::GAIN_P_RST;
            r_gain_i <= lfps_pkg::GAIN_I_RST;
            r_gain_d <= lfps_pkg::GAIN_D_RST;
            r_target <= '0;
            r_base_l <= lfps_pkg::BASE_L_RST;
            r_base_r <= lfps_pkg::BASE_R_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lfps_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data;
                lfps_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data;
                lfps_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data;
                lfps_pkg::CFG_TARGET: r_target <= i_cfg_data[lfps_pkg::ERR_W-1:0];
                lfps_pkg::CFG_BASE_L: r_base_l <= i_cfg_data[lfps_pkg::BASE_W-1:0];
                lfps_pkg::CFG_BASE_R: r_base_r <= i_cfg_data[lfps_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= lfps_pkg::ST_FETCH;
            r_out_valid <= 1'b0;
            r_right_sel <= 1'b0;
            r_held_err  <= '0;
            r_held_spd  <= '0;
            r_bias      <= '0;
            r_prev      <= '0;
            r_integ     <= '0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_right_sel <= n_right_sel;
            r_held_err  <= n_held_err;
            r_held_spd  <= n_held_spd;
            r_bias      <= n_bias;
            r_prev      <= n_prev;
            r_integ     <= n_integ;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_sensor    <= n_sensor;
        r_acc       <= n_acc;
        r_corr      <= n_corr;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_left      <= n_left;
        r_right     <= n_right;
        r_out_left  <= n_out_left;
        r_out_right <= n_out_right;
        r_out_err   <= n_out_err;
        r_out_spd   <= n_out_spd;
    end

endmodule

[dv/line_follow_pid_steering_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the line follower steering block with a scoreboard class and pid predictor
module line_follow_pid_steering_top_tb;

    localparam logic [lfps_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [lfps_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_ITEMS = 45;
    localparam int RAMP_ITEMS  = 1260;

    typedef struct packed {
        logic signed [lfps_pkg::DRIVE_W-1:0] left_drive;
        logic signed [lfps_pkg::DRIVE_W-1:0] right_drive;
        logic signed [lfps_pkg::ERR_W-1:0]   track_err;
        logic [lfps_pkg::SPEED_W-1:0]        speed;
    } t_drive;

    class drive_scoreboard;
        logic [lfps_pkg::GAIN_W-1:0]          gain_p, gain_i, gain_d;
        logic signed [lfps_pkg::ERR_W-1:0]    target;
        logic [lfps_pkg::BASE_W-1:0]          base_l, base_r;
        logic signed [lfps_pkg::ERR_W-1:0]    held_err;
        logic [lfps_pkg::SPEED_W-1:0]         held_spd;
        logic signed [lfps_pkg::BIAS_W-1:0]   stored_bias;
        logic signed [lfps_pkg::INTEG_W-1:0]  integ;
        t_drive expected_q[$];
        int errors;
        int checked;

        function new();
            gain_p      = lfps_pkg::GAIN_P_RST;
            gain_i      = lfps_pkg::GAIN_I_RST;
            gain_d      = lfps_pkg::GAIN_D_RST;
            target      = '0;
            base_l      = lfps_pkg::BASE_L_RST;
            base_r      = lfps_pkg::BASE_R_RST;
            held_err    = '0;
            held_spd    = '0;
            stored_bias = '0;
            integ       = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function longint scale_side(longint sum_q);
            longint v;
            longint spd;
            spd = held_spd;
            v = clamp(sum_q / 256, -100, 100);
            return (v * spd) / 100;
        endfunction

        function void set_reg(logic [lfps_pkg::CFG_IDX_W-1:0] idx,
                              logic [lfps_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lfps_pkg::CFG_GAIN_P: gain_p = data;
                lfps_pkg::CFG_GAIN_I: gain_i = data;
                lfps_pkg::CFG_GAIN_D: gain_d = data;
                lfps_pkg::CFG_TARGET: target = data[lfps_pkg::ERR_W-1:0];
                lfps_pkg::CFG_BASE_L: base_l = data[lfps_pkg::BASE_W-1:0];
                lfps_pkg::CFG_BASE_R: base_r = data[lfps_pkg::BASE_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sensor(logic [lfps_pkg::SENSOR_W-1:0] pat);
            int bias;
            int prev_bias;
            longint gp, gi, gd, bl, br, acc, corr;
            t_drive exp_d;
            case (pat)
                6'b111000: begin held_err = -5'sd11; held_spd = 7'd100; end
                6'b100000: begin held_err = -5'sd9;  held_spd = 7'd80;  end
                6'b110000: begin held_err = -5'sd7;  held_spd = 7'd85;  end
                6'b010000: begin held_err = -5'sd5;  held_spd = 7'd90;  end
                6'b011000: begin held_err = -5'sd3;  held_spd = 7'd95;  end
                6'b001000: begin held_err = -5'sd1;  held_spd = 7'd95;  end
                6'b000000: begin held_err = 5'sd0;   held_spd = 7'd100; end
                6'b000100: begin held_err = 5'sd1;   held_spd = 7'd95;  end
                6'b000110: begin held_err = 5'sd3;   held_spd = 7'd80;  end
                6'b000010: begin held_err = 5'sd5;   held_spd = 7'd85;  end
                6'b000011: begin held_err = 5'sd7;   held_spd = 7'd90;  end
                6'b000001: begin held_err = 5'sd9;   held_spd = 7'd95;  end
                6'b000111: begin held_err = 5'sd11;  held_spd = 7'd100; end
                6'b111111: held_spd = 7'd0;
                default: ;
            endcase
            prev_bias = stored_bias;
            bias = int'(held_err) - int'(target);
            stored_bias = bias[lfps_pkg::BIAS_W-1:0];
            gp = gain_p;
            gi = gain_i;
            gd = gain_d;
            bl = base_l;
            br = base_r;
            if (gain_i != 0)
                integ = 16'(clamp(longint'(integ) + bias, -32768, 32767));
            else
                integ = '0;
            acc = integ;
            corr = clamp(gp * bias + gi * acc + gd * (bias - prev_bias), -25600, 25600);
            exp_d.left_drive  = 8'(scale_side(bl * 256 + corr));
            exp_d.right_drive = 8'(scale_side(br * 256 - corr));
            exp_d.track_err   = held_err;
            exp_d.speed       = held_spd;
            expected_q.push_back(exp_d);
        endfunction

        function void check_drive(t_drive got);
            t_drive exp_d;
            if (expected_q.size() == 0) begin
                $error("drive transaction with nothing expected");
                errors++;
                return;
            end
            exp_d = expected_q.pop_front();
            checked++;
            if (got.left_drive !== exp_d.left_drive) begin
                $error("left_drive: expected %0d, actual %0d", exp_d.left_drive, got.left_drive);
                errors++;
            end
            if (got.right_drive !== exp_d.right_drive) begin
                $error("right_drive: expected %0d, actual %0d",
                       exp_d.right_drive, got.right_drive);
                errors++;
            end
            if (got.track_err !== exp_d.track_err) begin
                $error("track_error: expected %0d, actual %0d", exp_d.track_err, got.track_err);
                errors++;
            end
            if (got.speed !== exp_d.speed) begin
                $error("speed_percent: expected %0d, actual %0d", exp_d.speed, got.speed);
                errors++;
            end
        endfunction
    endclass

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_stall;
    logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_bits = '0;
    logic                                  o_out_valid;
    logic                                  i_out_stall = 1'b0;
    logic signed [lfps_pkg::DRIVE_W-1:0]   o_left_drive;
    logic signed [lfps_pkg::DRIVE_W-1:0]   o_right_drive;
    logic signed [lfps_pkg::ERR_W-1:0]     o_track_error;
    logic [lfps_pkg::SPEED_W-1:0]          o_speed_percent;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [lfps_pkg::CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [lfps_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    drive_scoreboard sb;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    int settings = 0;
    logic [lfps_pkg::SENSOR_W-1:0] listed_pats [0:13] = '{
        6'b111000, 6'b100000, 6'b110000, 6'b010000, 6'b011000, 6'b001000, 6'b000000,
        6'b000100, 6'b000110, 6'b000010, 6'b000011, 6'b000001, 6'b000111, 6'b111111
    };

    line_follow_pid_steering_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sensor_bits   (i_sensor_bits),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_drive    (o_left_drive),
        .o_right_drive   (o_right_drive),
        .o_track_error   (o_track_error),
        .o_speed_percent (o_speed_percent),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_drive got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && !i_out_stall) begin
                got.left_drive  = o_left_drive;
                got.right_drive = o_right_drive;
                got.track_err   = o_track_error;
                got.speed       = o_speed_percent;
                sb.check_drive(got);
            end
            if (i_in_valid && !o_in_stall)
                sb.note_sensor(i_sensor_bits);
        end
    end

    initial begin : out_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !steady && ($urandom_range(0, 99) < 33);
            end
        end
    end

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [15:0] pick_base();
        case ($urandom_range(0, 4))
            0: return {9'($urandom), 7'd0};
            1: return {9'($urandom), 7'd100};
            2: return {9'($urandom), 7'h7F};
            default: return {9'($urandom), 7'($urandom_range(0, 100))};
        endcase
    endfunction

    function automatic logic [5:0] pick_pattern();
        if ($urandom_range(0, 99) < 75)
            return listed_pats[$urandom_range(0, 13)];
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic send_sensor(input logic [5:0] pat);
        while (!steady && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sensor_bits <= pat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] gp, input logic [15:0] gi,
                            input logic [15:0] gd, input logic [15:0] tgt,
                            input logic [15:0] bl, input logic [15:0] br);
        write_reg(lfps_pkg::CFG_GAIN_P, gp);
        write_reg(lfps_pkg::CFG_GAIN_I, gi);
        write_reg(lfps_pkg::CFG_GAIN_D, gd);
        write_reg(lfps_pkg::CFG_TARGET, tgt);
        write_reg(lfps_pkg::CFG_BASE_L, bl);
        write_reg(lfps_pkg::CFG_BASE_R, br);
        write_reg(settings[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic push_ramp(input logic [5:0] pat, input int count);
        for (int k = 0; k < count; k++)
            send_sensor(($urandom_range(0, 99) < 96) ? pat : 6'($urandom_range(0, 63)));
    endtask

    initial begin : timeout
        #(24_000_000);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int p;
        int n;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: unlisted and brake before any decode, then the whole table
        send_sensor(6'b101010);
        send_sensor(6'b111111);
        for (n = 0; n < 13; n++)
            send_sensor(listed_pats[n]);
        send_sensor(6'b111111);
        send_sensor(6'b010101);
        drain();

        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFFF, 16'hFF80);
        send_sensor(6'b000111);
        send_sensor(6'b111000);
        send_sensor(6'b000000);
        drain();

        set_regs(16'd0, 16'd0, 16'd0, 16'h000F, 16'd100, 16'd100);
        send_sensor(6'b000001);
        send_sensor(6'b111000);
        drain();

        for (p = 0; p < PHASE_COUNT; p++) begin
            set_regs(pick_gain(), pick_gain(), pick_gain(), 16'($urandom),
                     pick_base(), pick_base());
            steady = (p == 2);
            if (p == 4)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sensor(pick_pattern());
            drain();
            steady = 1'b0;
        end

        // integral driven into its upper saturation limit, then cleared
        set_regs(16'($urandom_range(0, 1023)), 16'($urandom_range(1, 65535)), pick_gain(),
                 16'h0010, pick_base(), pick_base());
        push_ramp(6'b000111, RAMP_ITEMS);
        drain();
        set_regs(pick_gain(), 16'd0, pick_gain(), 16'($urandom), pick_base(), pick_base());
        for (n = 0; n < 10; n++)
            send_sensor(pick_pattern());
        drain();

        repeat (40) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            $error("%0d drive transactions never arrived", sb.expected_q.size());
        $display("summary: %0d drive transactions checked over %0d register settings,",
                 sb.checked, settings);
        $display("summary: table decode, brake, unlisted patterns, hold-off, integral limit");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
